/* rtl/core/bqsc_pkg.sv */
// Shared types and constants for the biquad filter with soft clip drive.
// Holds the configuration register map, reset values and fixed arithmetic widths.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package bqsc_pkg;

    // Default values of the top-level parameters
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Register field widths
    localparam int COEF_W     = 19;
    localparam int GAIN_W     = 19;
    localparam int RECIP_W    = 17;
    localparam int CFG_DATA_W = 19;
    localparam int CFG_IDX_W  = 4;

    // Soft clip internal format: magnitudes in Q.24, at most 8.0
    localparam int CLIP_FRAC = 24;
    localparam int CLIP_W    = 28;                  // clip input magnitude
    localparam int SQ_W      = 31;                  // m^2 in Q.24, at most 64.0
    localparam int NUM_W     = CLIP_W + SQ_W;       // numerator
    localparam int DEN_W     = 34;                  // denominator, below 2^34
    localparam int DIV_STEPS = CLIP_W;              // quotient never exceeds the input

    // 27.0 in Q.24
    localparam logic [DEN_W-1:0] K27 = 34'd452984832;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B0       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_EN = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP    = 4'd7;

    // Configuration as seen by the lanes
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic                     drive_en;
        logic [GAIN_W-1:0]        gain;
        logic [RECIP_W-1:0]       recip;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        b0:       19'sd65536,
        b1:       19'sd0,
        b2:       19'sd0,
        a1:       19'sd0,
        a2:       19'sd0,
        drive_en: 1'b0,
        gain:     19'd65536,
        recip:    17'd65536
    };

endpackage

/* rtl/core/bqsc_drive.sv */
// Soft clip drive stage of one lane: gain, Pade tanh curve, reciprocal gain.
// Sequenced by a state machine with a bit-serial restoring divider.
// Depends on bqsc_pkg.
module bqsc_drive #(
    parameter int SAMPLE_WIDTH   = bqsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqsc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [SAMPLE_WIDTH-1:0]    x_in,
    input  logic [bqsc_pkg::GAIN_W-1:0]       gain,
    input  logic [bqsc_pkg::RECIP_W-1:0]      recip,
    output logic                              done,
    output logic signed [SAMPLE_WIDTH-1:0]    y_out
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int F      = SW - 1;
    localparam int MW     = SW + 3;                               // magnitude up to 8.0
    localparam int PW     = SW + bqsc_pkg::GAIN_W;
    localparam int RW     = MW + bqsc_pkg::RECIP_W;
    localparam int CVW    = (MW > bqsc_pkg::CLIP_W) ? MW : bqsc_pkg::CLIP_W;
    localparam int SH_DN  = (F >= bqsc_pkg::CLIP_FRAC) ? F - bqsc_pkg::CLIP_FRAC : 0;
    localparam int SH_UP  = (F >= bqsc_pkg::CLIP_FRAC) ? 0 : bqsc_pkg::CLIP_FRAC - F;
    localparam int SQP_W  = 2 * bqsc_pkg::CLIP_W;
    localparam int CNT_W  = $clog2(bqsc_pkg::DIV_STEPS);
    localparam int CW     = bqsc_pkg::CLIP_W;
    localparam int DW     = bqsc_pkg::DEN_W;

    // 8.0 in sample format, and 1.0 for the output saturation check
    localparam logic [PW-1:0] LIM_PRE = {{(PW-SW-3){1'b0}}, 1'b1, {(SW+2){1'b0}}};
    localparam logic [RW-1:0] ONE_OUT = {{(RW-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [5:0] {
        D_IDLE = 6'b000001,
        D_GAIN = 6'b000010,
        D_SQ   = 6'b000100,
        D_NUM  = 6'b001000,
        D_DIV  = 6'b010000,
        D_OUT  = 6'b100000
    } drv_state_t;

    drv_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic [SW-1:0]           mag_reg, mag_next;
    logic [CW-1:0]           m24_reg, m24_next;
    logic [bqsc_pkg::SQ_W-1:0] m2_reg, m2_next;
    logic [DW-1:0]           rem_reg, rem_next;
    logic [CW-1:0]           qn_reg, qn_next;
    logic [DW-1:0]           den_reg, den_next;
    logic signed [SW-1:0]    y_reg, y_next;

    logic [PW-1:0]           prod_g;
    logic [PW-1:0]           m_sh;
    logic [PW-1:0]           m_cl;
    logic [CVW-1:0]          m_cv;
    logic [SQP_W-1:0]        sq_w;
    logic [bqsc_pkg::SQ_W-1:0] num_sum;
    logic [bqsc_pkg::NUM_W-1:0] num_w;
    logic [DW-1:0]           den_w;
    logic [DW:0]             trial;
    logic                    ge;
    logic [DW:0]             diff;
    logic [CVW-1:0]          qs;
    logic [RW-1:0]           prod_r;
    logic [RW-1:0]           r_sh;
    logic                    r_big;

    // Pre-clip gain, clamp at 8.0, move to Q.24
    assign prod_g = PW'(mag_reg) * PW'(gain);
    assign m_sh   = prod_g >> COEF_FRAC_BITS;
    assign m_cl   = (m_sh > LIM_PRE) ? LIM_PRE : m_sh;
    assign m_cv   = (CVW'(m_cl[MW-1:0]) >> SH_DN) << SH_UP;

    // Square, numerator and denominator of the Pade curve
    assign sq_w    = SQP_W'(m24_reg) * SQP_W'(m24_reg);
    assign num_sum = bqsc_pkg::K27[bqsc_pkg::SQ_W-1:0] + m2_reg;
    assign num_w   = bqsc_pkg::NUM_W'(m24_reg) * bqsc_pkg::NUM_W'(num_sum);
    assign den_w   = bqsc_pkg::K27 + (DW'(m2_reg) << 3) + DW'(m2_reg);

    // One restoring division step: shift in the next numerator bit
    assign trial = {rem_reg, qn_reg[CW-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    // Back to sample format, reciprocal gain, saturation check
    assign qs     = (CVW'(qn_reg) << SH_DN) >> SH_UP;
    assign prod_r = RW'(qs[MW-1:0]) * RW'(recip);
    assign r_sh   = prod_r >> COEF_FRAC_BITS;
    assign r_big  = (r_sh >= ONE_OUT);

    // Sequence the stage
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        m24_next   = m24_reg;
        m2_next    = m2_reg;
        rem_next   = rem_reg;
        qn_next    = qn_reg;
        den_next   = den_reg;
        y_next     = y_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next   = x_in[SW-1];
                    mag_next   = x_in[SW-1] ? (SW'(0) - $unsigned(x_in)) : $unsigned(x_in);
                    state_next = D_GAIN;
                end
            end
            D_GAIN:
            begin
                m24_next   = m_cv[CW-1:0];
                state_next = D_SQ;
            end
            D_SQ:
            begin
                m2_next    = sq_w[bqsc_pkg::SQ_W+bqsc_pkg::CLIP_FRAC-1:bqsc_pkg::CLIP_FRAC];
                state_next = D_NUM;
            end
            D_NUM:
            begin
                rem_next   = DW'(num_w[bqsc_pkg::NUM_W-1:CW]);
                qn_next    = num_w[CW-1:0];
                den_next   = den_w;
                cnt_next   = '0;
                state_next = D_DIV;
            end
            D_DIV:
            begin
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                qn_next  = {qn_reg[CW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(bqsc_pkg::DIV_STEPS - 1))
                begin
                    state_next = D_OUT;
                end
            end
            D_OUT:
            begin
                if (r_big)
                begin
                    y_next = neg_reg ? S_MIN : S_MAX;
                end
                else
                begin
                    y_next = neg_reg ? $signed(SW'(0) - r_sh[SW-1:0]) : $signed(r_sh[SW-1:0]);
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        m24_reg <= m24_next;
        m2_reg  <= m2_next;
        rem_reg <= rem_next;
        qn_reg  <= qn_next;
        den_reg <= den_next;
        y_reg   <= y_next;
    end

    assign done  = done_reg;
    assign y_out = y_reg;

endmodule

/* rtl/core/bqsc_biquad.sv */
// Direct form I biquad section of one lane with its own two-sample history.
// One shared multiplier walks the five taps; rounding and saturation at the end.
// Depends on bqsc_pkg.
module bqsc_biquad #(
    parameter int SAMPLE_WIDTH   = bqsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqsc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  bqsc_pkg::cfg_t                 cfg,
    output logic                           done,
    output logic signed [SAMPLE_WIDTH-1:0] y_out
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int PRW = SW + bqsc_pkg::COEF_W;
    localparam int AW  = PRW + 3;

    localparam logic [AW:0] HALF = {{AW{1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic [AW:0] LIM  = {{(AW+1-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam logic [2:0] TAP_B0 = 3'd0;
    localparam logic [2:0] TAP_B1 = 3'd1;
    localparam logic [2:0] TAP_B2 = 3'd2;
    localparam logic [2:0] TAP_A1 = 3'd3;
    localparam logic [2:0] TAP_A2 = 3'd4;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MAC  = 4'b0010,
        B_ACC  = 4'b0100,
        B_RND  = 4'b1000
    } bq_state_t;

    bq_state_t              state_reg, state_next;
    logic [2:0]             tap_reg, tap_next;
    logic                   pv_reg, pv_next;
    logic                   done_reg, done_next;
    logic signed [SW-1:0]   x1_reg, x1_next;
    logic signed [SW-1:0]   x2_reg, x2_next;
    logic signed [SW-1:0]   y1_reg, y1_next;
    logic signed [SW-1:0]   y2_reg, y2_next;
    logic signed [SW-1:0]   xin_reg, xin_next;
    logic signed [PRW-1:0]  prod_reg, prod_next;
    logic                   sub_reg, sub_next;
    logic signed [AW-1:0]   acc_reg, acc_next;

    logic signed [bqsc_pkg::COEF_W-1:0] coef_sel;
    logic signed [SW-1:0]   op_sel;
    logic                   sub_sel;
    logic signed [AW-1:0]   acc_add;
    logic                   neg;
    logic [AW-1:0]          mag;
    logic [AW:0]            sh;
    logic signed [SW-1:0]   y_w;

    // Select coefficient and operand for the current tap
    always_comb
    begin
        coef_sel = '0;
        op_sel   = '0;
        sub_sel  = 1'b0;
        case (tap_reg)
            TAP_B0:
            begin
                coef_sel = cfg.b0;
                op_sel   = xin_reg;
            end
            TAP_B1:
            begin
                coef_sel = cfg.b1;
                op_sel   = x1_reg;
            end
            TAP_B2:
            begin
                coef_sel = cfg.b2;
                op_sel   = x2_reg;
            end
            TAP_A1:
            begin
                coef_sel = cfg.a1;
                op_sel   = y1_reg;
                sub_sel  = 1'b1;
            end
            TAP_A2:
            begin
                coef_sel = cfg.a2;
                op_sel   = y2_reg;
                sub_sel  = 1'b1;
            end
            default:
            begin
                coef_sel = '0;
            end
        endcase
    end

    // Accumulate the product of the previous cycle
    assign acc_add = sub_reg ? (acc_reg - AW'(prod_reg)) : (acc_reg + AW'(prod_reg));

    // Round half away from zero, then saturate
    assign neg = acc_reg[AW-1];
    assign mag = neg ? (AW'(0) - $unsigned(acc_reg)) : $unsigned(acc_reg);
    assign sh  = ((AW+1)'(mag) + HALF) >> COEF_FRAC_BITS;

    always_comb
    begin
        if (neg)
        begin
            y_w = (sh > LIM) ? S_MIN : $signed(SW'(0) - sh[SW-1:0]);
        end
        else
        begin
            y_w = (sh >= LIM) ? S_MAX : $signed(sh[SW-1:0]);
        end
    end

    // Sequence the taps
    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        pv_next    = pv_reg;
        done_next  = 1'b0;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        y1_next    = y1_reg;
        y2_next    = y2_reg;
        xin_next   = xin_reg;
        prod_next  = prod_reg;
        sub_next   = sub_reg;
        acc_next   = acc_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    xin_next   = x_in;
                    tap_next   = TAP_B0;
                    pv_next    = 1'b0;
                    acc_next   = '0;
                    state_next = B_MAC;
                end
            end
            B_MAC:
            begin
                if (pv_reg)
                begin
                    acc_next = acc_add;
                end
                prod_next = PRW'(coef_sel) * PRW'(op_sel);
                sub_next  = sub_sel;
                pv_next   = 1'b1;
                tap_next  = tap_reg + 1'b1;
                if (tap_reg == TAP_A2)
                begin
                    state_next = B_ACC;
                end
            end
            B_ACC:
            begin
                acc_next   = acc_add;
                state_next = B_RND;
            end
            B_RND:
            begin
                x2_next    = x1_reg;
                x1_next    = xin_reg;
                y2_next    = y1_reg;
                y1_next    = y_w;
                done_next  = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            tap_reg   <= TAP_B0;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
            x1_reg    <= '0;
            x2_reg    <= '0;
            y1_reg    <= '0;
            y2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            y1_reg    <= y1_next;
            y2_reg    <= y2_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        xin_reg  <= xin_next;
        prod_reg <= prod_next;
        sub_reg  <= sub_next;
        acc_reg  <= acc_next;
    end

    assign done  = done_reg;
    assign y_out = y1_reg;

endmodule

/* rtl/core/bqsc_lane.sv */
// One channel lane: optional soft clip drive followed by the biquad section.
// Holds its result until the merge stage takes it.
// Depends on bqsc_pkg, bqsc_drive and bqsc_biquad.
module bqsc_lane #(
    parameter int SAMPLE_WIDTH   = bqsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqsc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  bqsc_pkg::cfg_t                 cfg,
    input  logic                           ack,
    output logic                           res_valid,
    output logic signed [SAMPLE_WIDTH-1:0] res_data
);

    logic                           drv_start;
    logic                           drv_done;
    logic signed [SAMPLE_WIDTH-1:0] drv_y;
    logic                           bq_start;
    logic signed [SAMPLE_WIDTH-1:0] bq_x;
    logic                           bq_done;
    logic signed [SAMPLE_WIDTH-1:0] bq_y;
    logic                           res_valid_reg, res_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] res_data_reg, res_data_next;

    // Route the sample through the drive stage only when it is enabled
    assign drv_start = start & cfg.drive_en;
    assign bq_start  = (start & ~cfg.drive_en) | drv_done;
    assign bq_x      = drv_done ? drv_y : x_in;

    bqsc_drive #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_drive (
        .clk   (clk),
        .rst_n (rst_n),
        .start (drv_start),
        .x_in  (x_in),
        .gain  (cfg.gain),
        .recip (cfg.recip),
        .done  (drv_done),
        .y_out (drv_y)
    );

    bqsc_biquad #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_biquad (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bq_start),
        .x_in  (bq_x),
        .cfg   (cfg),
        .done  (bq_done),
        .y_out (bq_y)
    );

    // Hold the result until acknowledged
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (bq_done)
        begin
            res_valid_next = 1'b1;
            res_data_next  = bq_y;
        end
        else if (ack)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

/* rtl/core/biquad_filter_with_soft_clip_drive_unit.sv */
// Top level of the stereo biquad filter with soft clip drive.
// Configuration registers, two channel lanes and the merging output register.
// Depends on bqsc_pkg and bqsc_lane.
//
//  channel   | direction | handshake         | content
//  ----------+-----------+-------------------+-----------------------------------------
//  s_*       | in        | s_tvalid/s_tready | left_in, right_in in tdata; mono in tuser
//  m_*       | out       | m_tvalid/m_tready | left_out, right_out in tdata
//  cfg_*     | in        | cfg_we            | register index and write data
//
// With drive on, a request passes the drive stage, mostly the 28-step restoring divider,
// before the five-tap shared multiplier; with drive off, only the shared multiplier.
// s_tready returns when the result moves into the output register, so a request waits
// for the last to merge; a stalled m_tready holds one result there and one in the lanes.
// rst_n clears the filter history and loads the register reset values.
module biquad_filter_with_soft_clip_drive_unit #(
    parameter int SAMPLE_WIDTH   = bqsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqsc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: left_in, right_in (from the lowest bit up), zero padded to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    // tuser: mono
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: left_out, right_out (from the lowest bit up), zero padded to bytes
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  m_tdata,
    input  logic                                 cfg_we,
    input  logic [bqsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bqsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = ((2*SW+7)/8)*8;

    bqsc_pkg::cfg_t   cfg_reg, cfg_next;
    logic             busy_reg, busy_next;
    logic             mono_reg, mono_next;
    logic             m_valid_reg, m_valid_next;
    logic [DW-1:0]    m_data_reg, m_data_next;

    logic             accept;
    logic             merge;
    logic             l_valid;
    logic             r_valid;
    logic signed [SW-1:0] l_data;
    logic signed [SW-1:0] r_data;

    // Decode configuration writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bqsc_pkg::REG_B0:       cfg_next.b0       = $signed(cfg_data[18:0]);
                bqsc_pkg::REG_B1:       cfg_next.b1       = $signed(cfg_data[18:0]);
                bqsc_pkg::REG_B2:       cfg_next.b2       = $signed(cfg_data[18:0]);
                bqsc_pkg::REG_A1:       cfg_next.a1       = $signed(cfg_data[18:0]);
                bqsc_pkg::REG_A2:       cfg_next.a2       = $signed(cfg_data[18:0]);
                bqsc_pkg::REG_DRIVE_EN: cfg_next.drive_en = cfg_data[0];
                bqsc_pkg::REG_GAIN:     cfg_next.gain     = cfg_data[18:0];
                bqsc_pkg::REG_RECIP:    cfg_next.recip    = cfg_data[16:0];
                default:                cfg_next          = cfg_reg;
            endcase
        end
    end

    // Accept one request at a time
    assign s_tready = ~busy_reg;
    assign accept   = s_tvalid & s_tready;

    bqsc_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .x_in      ($signed(s_tdata[SW-1:0])),
        .cfg       (cfg_reg),
        .ack       (merge),
        .res_valid (l_valid),
        .res_data  (l_data)
    );

    bqsc_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept & ~s_tuser),
        .x_in      ($signed(s_tdata[2*SW-1:SW])),
        .cfg       (cfg_reg),
        .ack       (merge),
        .res_valid (r_valid),
        .res_data  (r_data)
    );

    // Merge lane results into the output register when it is free
    assign merge = busy_reg & l_valid & (mono_reg | r_valid) & (~m_valid_reg | m_tready);

    always_comb
    begin
        busy_next    = busy_reg;
        mono_next    = mono_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            mono_next = s_tuser;
        end
        if (merge)
        begin
            busy_next              = 1'b0;
            m_valid_next           = 1'b1;
            m_data_next            = '0;
            m_data_next[SW-1:0]    = l_data;
            m_data_next[2*SW-1:SW] = mono_reg ? '0 : r_data;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= bqsc_pkg::CFG_RESET;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mono_reg   <= mono_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The right lane stays quiet for a mono request
    a_mono_right_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && mono_reg |-> !r_valid)
        else $error("right lane produced a result during a mono request");

    // No stale lane result survives into a new request
    a_accept_clean : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !l_valid && !r_valid)
        else $error("lane result pending when a new request was accepted");

    // A lane result only exists while a request is in flight
    a_result_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        l_valid || r_valid |-> busy_reg)
        else $error("lane result present with no request in flight");

endmodule

/* tb/biquad_checker.sv */
`timescale 1ns / 100ps
// Checker for the biquad filter with soft clip drive: tracks register writes, predicts
// each filtered sample pair from the accepted requests and compares the results.
// Depends on bqsc_pkg for register indexes and field widths.
module biquad_checker (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_tvalid,
    input  logic                                             s_tready,
    // tdata: left_in, right_in (from the lowest bit up)
    input  logic [((2*bqsc_pkg::SAMPLE_WIDTH_DEF+7)/8)*8-1:0] s_tdata,
    // tuser: mono
    input  logic                                             s_tuser,
    input  logic                                             m_tvalid,
    input  logic                                             m_tready,
    // tdata: left_out, right_out (from the lowest bit up)
    input  logic [((2*bqsc_pkg::SAMPLE_WIDTH_DEF+7)/8)*8-1:0] m_tdata,
    input  logic                                             cfg_we,
    input  logic [bqsc_pkg::CFG_IDX_W-1:0]                   cfg_index,
    input  logic [bqsc_pkg::CFG_DATA_W-1:0]                  cfg_data,
    output logic [31:0]                                      mismatches,
    output logic [31:0]                                      pending,
    output logic [31:0]                                      checked
);

    localparam int SW = bqsc_pkg::SAMPLE_WIDTH_DEF;
    localparam int CF = bqsc_pkg::COEF_FRAC_BITS_DEF;
    localparam int CLIP_FRAC = bqsc_pkg::CLIP_FRAC;
    localparam longint SMAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam longint unsigned DRIVE_LIMIT = 64'd8 << (SW - 1);
    localparam longint unsigned K27_Q24 = 64'd27 << CLIP_FRAC;
    localparam longint unsigned ROUND_HALF = 64'd1 << (CF - 1);

    typedef logic signed [SW-1:0] sample_t;
    typedef struct packed {
        sample_t left;
        sample_t right;
    } pair_t;

    // Mirror of the register file
    logic signed [bqsc_pkg::COEF_W-1:0] tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
    logic                               drive_on;
    logic [bqsc_pkg::GAIN_W-1:0]        pre_gain;
    logic [bqsc_pkg::RECIP_W-1:0]       post_gain;

    // Filter history per channel: [2*ch] one sample back, [2*ch+1] two back
    longint x_hist [4];
    longint y_hist [4];

    pair_t expected_pairs [$];
    int    n_bad;
    int    n_checked;

    function automatic sample_t clamp_sample(input longint v);
        if (v > SMAX)
            v = SMAX;
        else if (v < SMIN)
            v = SMIN;
        return v[SW-1:0];
    endfunction

    // Gain, Pade soft clip and reciprocal gain, on the magnitude
    function automatic sample_t soft_clip_drive(input sample_t x);
        logic                 neg;
        longint               sv;
        longint unsigned      mag, m, m24, m2, num, den, q, r;
        neg = x[SW-1];
        sv  = longint'(x);
        mag = neg ? longint'(-sv) : sv;
        m   = (mag * longint'(pre_gain)) >> CF;
        if (m > DRIVE_LIMIT)
            m = DRIVE_LIMIT;
        m24 = m << (CLIP_FRAC - (SW - 1));
        m2  = (m24 * m24) >> CLIP_FRAC;
        num = m24 * (K27_Q24 + m2);
        den = K27_Q24 + 64'd9 * m2;
        q   = num / den;
        q   = q >> (CLIP_FRAC - (SW - 1));
        r   = (q * longint'(post_gain)) >> CF;
        if (r > DRIVE_LIMIT)
            r = DRIVE_LIMIT;
        sv = longint'(r);
        return clamp_sample(neg ? -sv : sv);
    endfunction

    // Direct form I section, round half away from zero, then shift the history
    function automatic sample_t filter_channel(input sample_t x, input int ch);
        int              b;
        longint          acc;
        longint          y;
        logic            neg;
        longint unsigned mag;
        sample_t         y_sat;
        b   = ch * 2;
        acc = longint'(tap_b0) * longint'(x) + longint'(tap_b1) * x_hist[b]
            + longint'(tap_b2) * x_hist[b+1] - longint'(tap_a1) * y_hist[b]
            - longint'(tap_a2) * y_hist[b+1];
        neg = acc < 0;
        mag = neg ? -acc : acc;
        mag = (mag + ROUND_HALF) >> CF;
        y   = neg ? -longint'(mag) : longint'(mag);
        y_sat = clamp_sample(y);
        x_hist[b+1] = x_hist[b];
        x_hist[b]   = longint'(x);
        y_hist[b+1] = y_hist[b];
        y_hist[b]   = longint'(y_sat);
        return y_sat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        pair_t   want;
        pair_t   got;
        sample_t l_in;
        sample_t r_in;
        if (!rst_n)
        begin
            tap_b0    = 19'sd65536;
            tap_b1    = '0;
            tap_b2    = '0;
            tap_a1    = '0;
            tap_a2    = '0;
            drive_on  = 1'b0;
            pre_gain  = 19'd65536;
            post_gain = 17'd65536;
            for (int i = 0; i < 4; i++)
            begin
                x_hist[i] = 0;
                y_hist[i] = 0;
            end
            expected_pairs.delete();
            n_bad      = 0;
            n_checked  = 0;
            mismatches <= '0;
            pending    <= '0;
            checked    <= '0;
        end
        else
        begin
            // Compare a delivered result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.left  = m_tdata[SW-1:0];
                got.right = m_tdata[2*SW-1:SW];
                if (expected_pairs.size() == 0)
                begin
                    n_bad++;
                    $display("%0t: result with no request outstanding, expected none, %s",
                             $time, $sformatf("got %0d / %0d", got.left, got.right));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    n_checked++;
                    if (got.left !== want.left)
                    begin
                        n_bad++;
                        $display("%0t: left_out mismatch, expected %0d, got %0d",
                                 $time, want.left, got.left);
                    end
                    if (got.right !== want.right)
                    begin
                        n_bad++;
                        $display("%0t: right_out mismatch, expected %0d, got %0d",
                                 $time, want.right, got.right);
                    end
                end
            end

            // Predict the pair for an accepted request
            if (s_tvalid && s_tready)
            begin
                l_in = s_tdata[SW-1:0];
                r_in = s_tdata[2*SW-1:SW];
                if (drive_on)
                    l_in = soft_clip_drive(l_in);
                want.left  = filter_channel(l_in, 0);
                want.right = '0;
                if (!s_tuser)
                begin
                    if (drive_on)
                        r_in = soft_clip_drive(r_in);
                    want.right = filter_channel(r_in, 1);
                end
                expected_pairs.push_back(want);
            end

            // Register writes; unused indexes drop the write
            if (cfg_we)
            begin
                case (cfg_index)
                    bqsc_pkg::REG_B0:       tap_b0    = cfg_data[bqsc_pkg::COEF_W-1:0];
                    bqsc_pkg::REG_B1:       tap_b1    = cfg_data[bqsc_pkg::COEF_W-1:0];
                    bqsc_pkg::REG_B2:       tap_b2    = cfg_data[bqsc_pkg::COEF_W-1:0];
                    bqsc_pkg::REG_A1:       tap_a1    = cfg_data[bqsc_pkg::COEF_W-1:0];
                    bqsc_pkg::REG_A2:       tap_a2    = cfg_data[bqsc_pkg::COEF_W-1:0];
                    bqsc_pkg::REG_DRIVE_EN: drive_on  = cfg_data[0];
                    bqsc_pkg::REG_GAIN:     pre_gain  = cfg_data[bqsc_pkg::GAIN_W-1:0];
                    bqsc_pkg::REG_RECIP:    post_gain = cfg_data[bqsc_pkg::RECIP_W-1:0];
                    default:                ;
                endcase
            end

            mismatches <= n_bad;
            pending    <= expected_pairs.size();
            checked    <= n_checked;
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Regression top for the biquad filter with soft clip drive: clock, reset, requests,
// register settings, output back-pressure, watchdog and verdict.
// Depends on bqsc_pkg, the block itself and biquad_checker.
module tb;

    localparam int SW            = bqsc_pkg::SAMPLE_WIDTH_DEF;
    localparam int TW            = ((2*SW+7)/8)*8;
    localparam int CDW           = bqsc_pkg::CFG_DATA_W;
    localparam int CIW           = bqsc_pkg::CFG_IDX_W;
    localparam int RW            = bqsc_pkg::RECIP_W;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 96;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 60;

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_NEG_ONE = {SW{1'b1}};
    localparam logic [SW-1:0] S_ONE = 24'd1;
    localparam logic [SW-1:0] S_HALF = 24'd4194304;
    localparam logic [CDW-1:0] COEF_MAX = 19'h3FFFF;
    localparam logic [CDW-1:0] COEF_MIN = 19'h40000;
    localparam logic [CDW-1:0] GAIN_LO  = 19'd65536;
    localparam logic [CDW-1:0] GAIN_HI  = 19'd327680;
    localparam logic [CDW-1:0] RECIP_LO = 19'd13107;
    localparam logic [CDW-1:0] RECIP_HI = 19'd65536;
    localparam logic [CIW-1:0] REG_UNUSED_LO = 4'd8;
    localparam logic [CIW-1:0] REG_UNUSED_HI = 4'd15;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TW-1:0]         s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TW-1:0]         m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CIW-1:0]        cfg_index = '0;
    logic [CDW-1:0]        cfg_data  = '0;

    logic [31:0] fail_total;
    logic [31:0] pending_total;
    logic [31:0] checked_total;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int sent_total     = 0;
    int drive_phases   = 0;

    biquad_filter_with_soft_clip_drive_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    biquad_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (fail_total),
        .pending    (pending_total),
        .checked    (checked_total)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Stall the result side at the current rate
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort when no request moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [CDW-1:0] coef_val(input int v);
        return v[CDW-1:0];
    endfunction

    function automatic logic [CDW-1:0] rand_coef(input int lo, input int hi);
        int v;
        v = lo + int'($urandom_range(0, hi - lo));
        return coef_val(v);
    endfunction

    // Mostly full-range samples, with extremes, small values and 0 / -1 mixed in
    function automatic logic [SW-1:0] rand_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return {{(SW-9){raw[8]}}, raw[8:0]};
            3:       return {SW{raw[0]}};
            default: return raw[SW-1:0];
        endcase
    endfunction

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Hold one request until the block takes it, after a random gap
    task automatic send_item(input logic [SW-1:0] left_s, input logic [SW-1:0] right_s,
                             input logic mono_s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right_s, left_s};
        s_tuser  <= mono_s;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_total++;
    endtask

    // Drop valid and wait until every predicted pair has been delivered
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_total != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all eight registers with a random setting of the given style
    task automatic load_setting(input int style);
        logic [CDW-1:0] b0, b1, b2, a1, a2, en, gain, recip;
        logic [31:0]    raw;
        int             a2_i;
        int             a1_lim;
        case (style)
            0:
            begin
                // stable section: |a2| < 1, |a1| < 1 + a2
                b0     = rand_coef(-32768, 32767);
                b1     = rand_coef(-32768, 32767);
                b2     = rand_coef(-32768, 32767);
                a2_i   = int'($urandom_range(0, 58982));
                a1_lim = ((65536 + a2_i) * 9) / 10;
                a1     = rand_coef(-a1_lim, a1_lim);
                a2     = coef_val(a2_i);
            end
            1:
            begin
                b0 = rand_coef(-262144, 262143);
                b1 = rand_coef(-262144, 262143);
                b2 = rand_coef(-262144, 262143);
                a1 = rand_coef(-262144, 262143);
                a2 = rand_coef(-262144, 262143);
            end
            default:
            begin
                b0 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                b1 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                b2 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                a1 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                a2 = $urandom_range(0, 1) ? COEF_MAX : '0;
            end
        endcase
        raw = $urandom();
        en  = raw[CDW-1:0];
        en[0] = ($urandom_range(0, 99) < 60);
        if (en[0])
            drive_phases++;
        case ($urandom_range(0, 5))
            0:       gain = GAIN_LO;
            1:       gain = GAIN_HI;
            2:
            begin
                raw  = $urandom();
                gain = raw[CDW-1:0];
            end
            default:
            begin
                raw  = $urandom_range(65536, 327680);
                gain = raw[CDW-1:0];
            end
        endcase
        case ($urandom_range(0, 5))
            0:       recip = RECIP_LO;
            1:       recip = RECIP_HI;
            2:
            begin
                raw   = $urandom();
                recip = raw[CDW-1:0];
            end
            default:
            begin
                raw   = $urandom_range(13107, 65536);
                recip = raw[CDW-1:0];
                raw   = $urandom();
                recip[CDW-1:RW] = raw[CDW-RW-1:0];
            end
        endcase
        write_reg(bqsc_pkg::REG_B0, b0);
        write_reg(bqsc_pkg::REG_B1, b1);
        write_reg(bqsc_pkg::REG_B2, b2);
        write_reg(bqsc_pkg::REG_A1, a1);
        write_reg(bqsc_pkg::REG_A2, a2);
        write_reg(bqsc_pkg::REG_DRIVE_EN, en);
        write_reg(bqsc_pkg::REG_GAIN, gain);
        write_reg(bqsc_pkg::REG_RECIP, recip);
        if ($urandom_range(0, 3) == 0)
        begin
            raw = $urandom();
            write_reg(REG_UNUSED_LO + CIW'($urandom_range(0, 7)), raw[CDW-1:0]);
        end
        end_writes();
    endtask

    initial
    begin : stimulus
        logic [31:0] raw;
        int          style;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset setting passes samples through: field extremes, stereo and mono
        send_item(S_MAX, S_MIN, 1'b0);
        send_item(S_MIN, S_MAX, 1'b0);
        send_item('0, '0, 1'b0);
        send_item(S_NEG_ONE, S_ONE, 1'b0);
        send_item(S_MAX, S_NEG_ONE, 1'b1);
        send_item(S_MIN, S_MAX, 1'b1);
        drain_results();

        // Extreme coefficients drive the accumulator into saturation
        write_reg(bqsc_pkg::REG_B0, COEF_MAX);
        write_reg(bqsc_pkg::REG_B1, COEF_MIN);
        write_reg(bqsc_pkg::REG_B2, COEF_MAX);
        end_writes();
        send_item(S_MAX, S_MIN, 1'b0);
        send_item(S_MIN, S_MAX, 1'b0);
        send_item(S_ONE, S_NEG_ONE, 1'b0);
        drain_results();

        // Drive on at the top of the normal gain range, resonant section
        write_reg(bqsc_pkg::REG_B0, coef_val(32768));
        write_reg(bqsc_pkg::REG_B1, coef_val(16384));
        write_reg(bqsc_pkg::REG_B2, coef_val(8192));
        write_reg(bqsc_pkg::REG_A1, coef_val(-45875));
        write_reg(bqsc_pkg::REG_A2, coef_val(16384));
        write_reg(bqsc_pkg::REG_DRIVE_EN, 19'd1);
        write_reg(bqsc_pkg::REG_GAIN, GAIN_HI);
        write_reg(bqsc_pkg::REG_RECIP, RECIP_LO);
        end_writes();
        send_item(S_MAX, S_MIN, 1'b0);
        send_item(S_MIN, S_MAX, 1'b0);
        send_item('0, S_ONE, 1'b0);
        send_item(24'd1000, S_NEG_ONE, 1'b0);
        send_item(S_HALF, S_MAX, 1'b1);
        drain_results();

        // Largest pre-gain and post-gain: drive output runs past the sample range
        write_reg(bqsc_pkg::REG_GAIN, 19'h7FFFF);
        write_reg(bqsc_pkg::REG_RECIP, 19'h1FFFF);
        end_writes();
        send_item(S_MAX, S_MIN, 1'b0);
        send_item(S_MIN, S_MAX, 1'b0);
        send_item(S_HALF, S_HALF, 1'b0);
        send_item(S_MIN, S_MIN, 1'b1);
        drain_results();

        // Unused indexes must not touch any register; drive off via bit 0 only
        raw = $urandom();
        write_reg(REG_UNUSED_LO, raw[CDW-1:0]);
        write_reg(REG_UNUSED_HI, 19'h7FFFF);
        write_reg(bqsc_pkg::REG_DRIVE_EN, 19'h7FFFE);
        end_writes();
        send_item(S_MAX, S_MIN, 1'b0);
        send_item(S_HALF, S_NEG_ONE, 1'b0);

        // Random phases over settings and idle mixes
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 78;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct <= 22;
                end
            endcase
            style = ((p % 5) == 4) ? 2 : (((p % 5) == 2) ? 1 : 0);
            load_setting(style);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Let the block run dry once in a while
                if (k == PHASE_ITEMS / 2 && (p % 3) == 0)
                    drain_results();
                send_item(rand_sample(), rand_sample(), $urandom_range(0, 99) < 30);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests: directed extremes, then %0d random settings %s",
                 sent_total, PHASES, $sformatf("(%0d with drive)", drive_phases));
        $display("under four idle mixes; %0d result pairs compared, %0d mismatches.",
                 checked_total, fail_total);
        if (fail_total == 0 && pending_total == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bqsc_pkg.sv
rtl/core/bqsc_drive.sv
rtl/core/bqsc_biquad.sv
rtl/core/bqsc_lane.sv
rtl/core/biquad_filter_with_soft_clip_drive_unit.sv
tb/biquad_checker.sv
tb/tb.sv
